FILE: rtl/core/periodic_timer_bank_unit_assert.svh
// Assertion macros shared by the timer bank modules.
`ifndef PERIODIC_TIMER_BANK_UNIT_ASSERT_SVH
`define PERIODIC_TIMER_BANK_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTB_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// Next-cycle implication, checked outside reset.
`define PTB_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

FILE: rtl/core/ptb_pkg.sv
package ptb_pkg;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 5;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 6;

  // Bank size default and visit ceiling per tick
  localparam int NUM_TIMERS_DEF = 32;
  localparam int MAX_VISIT      = 32;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARM    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISARM = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } ptb_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // input item taken this cycle
    logic start_tick;  // tick item taken: set up a sweep
    logic scan;        // sweep in progress
    logic flush;       // sweep over: hand out the held result
  } ptb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;   // every timer in the sweep visited and evaluated
    logic pend_vld;    // a fired result is being held back
    logic out_free;    // output register can take a result
  } ptb_status_t;

endpackage

FILE: rtl/core/periodic_timer_bank_unit.sv
// Channel  Handshake            Payload
// in       in_valid/in_ready    kind, timer_index, timeout, interval
// out      out_valid/out_ready  fired_index, last
// cfg      cfg_valid/cfg_ready  cfg_data (timers_in_use)
//
// Arm, disarm and unused kinds are taken in idle; input is ready again next cycle.
// A tick runs a sweep: it reads one timer entry per cycle, unless stalled, from the
// count/reload memories, overlapped with write-back of the previous one, then
// finishes the sweep and flushes the held result.
// Reset is synchronous; no clearing pass, live bits clear at once.
// A stalled output holds the sweep only when a second firing needs the register.
module periodic_timer_bank_unit #(
  parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ptb_pkg::KIND_W-1:0]  kind,
  input  logic [ptb_pkg::INDEX_W-1:0] timer_index,
  input  logic [ptb_pkg::DATA_W-1:0]  timeout,
  input  logic [ptb_pkg::DATA_W-1:0]  interval,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ptb_pkg::INDEX_W-1:0] fired_index,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ptb_pkg::CFG_W-1:0]   cfg_data
);
  import ptb_pkg::*;

  ptb_cmd_t    cmd;
  ptb_status_t status;

  // Sequencer
  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .status   (status),
    .cmd      (cmd)
  );

  // Timer store, sweep and output register
  ptb_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .kind        (kind),
    .timer_index (timer_index),
    .timeout     (timeout),
    .interval    (interval),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fired_index (fired_index),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

endmodule

FILE: rtl/core/ptb_datapath.sv
module ptb_datapath #(
  parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ptb_pkg::ptb_cmd_t           cmd,
  output ptb_pkg::ptb_status_t        status,
  input  logic [ptb_pkg::KIND_W-1:0]  kind,
  input  logic [ptb_pkg::INDEX_W-1:0] timer_index,
  input  logic [ptb_pkg::DATA_W-1:0]  timeout,
  input  logic [ptb_pkg::DATA_W-1:0]  interval,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ptb_pkg::INDEX_W-1:0] fired_index,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ptb_pkg::CFG_W-1:0]   cfg_data
);
  import ptb_pkg::*;

  localparam int IDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W     = $clog2(NUM_TIMERS + 1);
  localparam int VISIT_MAX = (NUM_TIMERS < MAX_VISIT) ? NUM_TIMERS : MAX_VISIT;
  localparam logic [CFG_W-1:0] VISIT_MAX_C = CFG_W'(VISIT_MAX);

  // Timer store: count and reload in memory, one live bit per entry
  logic [DATA_W-1:0] count_mem  [NUM_TIMERS];
  logic [DATA_W-1:0] reload_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] live;

  logic [CFG_W-1:0]  timers_in_use;
  logic [CNT_W-1:0]  visit_n;
  logic [CNT_W-1:0]  scan_idx;
  logic              eval_vld;
  logic [IDX_W-1:0]  eval_idx;
  logic [DATA_W-1:0] rd_count;
  logic [DATA_W-1:0] rd_reload;
  logic              rd_live;
  logic              pend_vld;
  logic [IDX_W-1:0]  pend_idx;

  logic              in_range;
  logic [IDX_W-1:0]  in_addr;
  logic              do_arm;
  logic              do_disarm;
  logic [CFG_W-1:0]  visit_clip;
  logic              rd_go;
  logic [DATA_W-1:0] count_cur;
  logic [DATA_W-1:0] reload_cur;
  logic              dec;
  logic              fire;
  logic              out_free;
  logic              stall;
  logic              commit;
  logic              push_mid;
  logic              push_end;
  logic              cnt_we;
  logic [IDX_W-1:0]  cnt_waddr;
  logic [DATA_W-1:0] cnt_wdata;

  // Arm / disarm decode
  assign in_range  = int'(timer_index) < NUM_TIMERS;
  assign in_addr   = IDX_W'(timer_index);
  assign do_arm    = cmd.accept && (kind == KIND_ARM) && in_range;
  assign do_disarm = cmd.accept && (kind == KIND_DISARM) && in_range;

  // Timers visited per tick
  assign visit_clip = (timers_in_use > VISIT_MAX_C) ? VISIT_MAX_C : timers_in_use;

  // Evaluate the timer whose entry sits in the read registers
  assign count_cur  = rd_live ? rd_count  : '0;
  assign reload_cur = rd_live ? rd_reload : '0;
  assign dec        = eval_vld && (count_cur != '0);
  assign fire       = dec && (count_cur == DATA_W'(1));
  assign out_free   = !out_valid || out_ready;
  assign stall      = fire && pend_vld && !out_free;
  assign commit     = cmd.scan && eval_vld && !stall;
  assign rd_go      = cmd.scan && !stall && (scan_idx != visit_n);
  assign push_mid   = commit && fire && pend_vld;
  assign push_end   = cmd.flush && pend_vld && out_free;

  // Count write port: arm/disarm when idle, write-back during a sweep
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = in_addr;
    cnt_wdata = timeout;
    if (do_arm) begin
      cnt_we = 1'b1;
    end else if (do_disarm) begin
      cnt_we    = 1'b1;
      cnt_wdata = '0;
    end else if (commit && dec) begin
      cnt_we    = 1'b1;
      cnt_waddr = eval_idx;
      cnt_wdata = fire ? reload_cur : (count_cur - DATA_W'(1));
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    if (do_arm) begin
      reload_mem[in_addr] <= interval;
    end
    if (rd_go) begin
      rd_count  <= count_mem[scan_idx[IDX_W-1:0]];
      rd_reload <= reload_mem[scan_idx[IDX_W-1:0]];
      rd_live   <= live[scan_idx[IDX_W-1:0]];
    end
  end

  // Live bits: an entry reads as zero until first armed
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (do_arm) begin
      live[in_addr] <= 1'b1;
    end
  end

  // Config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      timers_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      timers_in_use <= cfg_data;
    end
  end

  // Sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      visit_n  <= '0;
      scan_idx <= '0;
      eval_vld <= 1'b0;
    end else if (cmd.start_tick) begin
      visit_n  <= CNT_W'(visit_clip);
      scan_idx <= '0;
      eval_vld <= 1'b0;
    end else if (cmd.scan && !stall) begin
      eval_vld <= rd_go;
      if (rd_go) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      eval_idx <= scan_idx[IDX_W-1:0];
    end
  end

  // Held result: released once the next firing or the sweep end shows its mark
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_vld <= 1'b0;
    end else if (commit && fire) begin
      pend_vld <= 1'b1;
    end else if (push_end) begin
      pend_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && fire) begin
      pend_idx <= eval_idx;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || push_end) begin
      fired_index <= INDEX_W'(pend_idx);
      last        <= push_end;
    end
  end

  assign status.scan_done = (scan_idx == visit_n) && !eval_vld;
  assign status.pend_vld  = pend_vld;
  assign status.out_free  = out_free;

`include "periodic_timer_bank_unit_assert.svh"

  `PTB_ASSERT_NEXT(a_stall_holds, clk, rst, stall, eval_vld && $stable(eval_idx))
  `PTB_ASSERT_NOW(a_eval_in_range, clk, rst, eval_vld, CNT_W'(eval_idx) < visit_n)
  `PTB_ASSERT_NOW(a_scan_bound, clk, rst, cmd.scan, scan_idx <= visit_n)

endmodule

FILE: rtl/core/ptb_ctrl.sv
module ptb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ptb_pkg::KIND_W-1:0] kind,
  input  ptb_pkg::ptb_status_t       status,
  output ptb_pkg::ptb_cmd_t          cmd
);
  import ptb_pkg::*;

  ptb_state_t state;
  ptb_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (kind == KIND_TICK)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!status.pend_vld || status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.accept     = in_valid;
        cmd.start_tick = in_valid && (kind == KIND_TICK);
      end
      ST_SCAN:  cmd.scan  = 1'b1;
      ST_FLUSH: cmd.flush = 1'b1;
      default: ;
    endcase
  end

`include "periodic_timer_bank_unit_assert.svh"

  `PTB_ASSERT_NEXT(a_tick_starts_sweep, clk, rst, cmd.start_tick, state == ST_SCAN)
  `PTB_ASSERT_NEXT(a_flush_ends, clk, rst, state == ST_FLUSH && !status.pend_vld, state == ST_IDLE)

endmodule
